// ===== sv/tfc_pkg.sv =====
`default_nettype none
package tfc_pkg;

  // Coordinate width and the widths that follow from it
  localparam int COORD_W  = 32;
  localparam int EDGE_W   = COORD_W + 1;          // v1 - v0, signed
  localparam int NRM_W    = 2 * COORD_W + 3;      // normal component, signed
  localparam int MUL_W    = 2 * COORD_W + 4;      // multiplier operand, unsigned
  localparam int MUL_H    = MUL_W / 2;            // partial product slice
  localparam int PROD_W   = 2 * MUL_W;            // multiplier result
  localparam int DOT_W    = NRM_W + COORD_W + 2;  // n . v0, signed
  localparam int DABS_W   = 3 * COORD_W + 2;      // |n . v0|
  localparam int DLO_W    = DABS_W / 2;
  localparam int DHI_W    = DABS_W - DLO_W;
  localparam int N2_W     = 4 * COORD_W + 4;      // |n|^2
  localparam int N2LO_W   = N2_W / 2;
  localparam int N2HI_W   = N2_W - N2LO_W;
  localparam int P2_W     = 2 * COORD_W;          // |v0|^2
  localparam int P_W      = N2_W + P2_W;          // |n|^2 * |v0|^2
  localparam int DSQ_W    = 2 * DABS_W;           // (n . v0)^2
  localparam int SCALE_SH = 32;                   // 65536^2
  localparam int R_W      = DSQ_W + SCALE_SH;
  localparam int Q_W      = SCALE_SH + 1;         // floor(R / P) <= 2^32
  localparam int S_W      = (Q_W + 1) / 2;        // isqrt result
  localparam int RAD_W    = 2 * S_W;
  localparam int RM_W     = S_W + 3;
  localparam int COS_W    = 16;

  localparam logic [COS_W-1:0] COS_MAX = {1'b0, {(COS_W-1){1'b1}}};
  localparam logic [Q_W-1:0]   Q_MAX   = {1'b1, {(Q_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } coord_vec_t;

  typedef struct packed {
    coord_vec_t v0;
    coord_vec_t v1;
    coord_vec_t v2;
  } triangle_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] x;
    logic signed [EDGE_W-1:0] y;
    logic signed [EDGE_W-1:0] z;
  } edge_vec_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
  } nrm_vec_t;

  // Control that rides along the back half of the pipeline
  typedef struct packed {
    logic vld;
    logic neg;
    logic deg;
  } side_t;

  function automatic logic [MUL_W-1:0] abs_edge(input logic signed [EDGE_W-1:0] v);
    logic signed [EDGE_W:0] t;
    t = (EDGE_W+1)'(v);
    if (v[EDGE_W-1]) t = -t;
    return MUL_W'(t);
  endfunction

  function automatic logic [MUL_W-1:0] abs_coord(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W:0] t;
    t = (COORD_W+1)'(v);
    if (v[COORD_W-1]) t = -t;
    return MUL_W'(t);
  endfunction

  function automatic logic [MUL_W-1:0] abs_nrm(input logic signed [NRM_W-1:0] v);
    logic signed [NRM_W:0] t;
    t = (NRM_W+1)'(v);
    if (v[NRM_W-1]) t = -t;
    return MUL_W'(t);
  endfunction

  function automatic logic signed [NRM_W-1:0] sgn_nrm(input logic [PROD_W-1:0] p,
                                                      input logic neg);
    logic signed [NRM_W-1:0] t;
    t = $signed(p[NRM_W-1:0]);
    return neg ? -t : t;
  endfunction

  function automatic logic signed [DOT_W-1:0] sgn_dot(input logic [PROD_W-1:0] p,
                                                      input logic neg);
    logic signed [DOT_W-1:0] t;
    t = $signed(p[DOT_W-1:0]);
    return neg ? -t : t;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tfc_in_if.sv =====
`default_nettype none
interface tfc_in_if import tfc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] v0_x;
  logic signed [COORD_W-1:0] v0_y;
  logic signed [COORD_W-1:0] v0_z;
  logic signed [COORD_W-1:0] v1_x;
  logic signed [COORD_W-1:0] v1_y;
  logic signed [COORD_W-1:0] v1_z;
  logic signed [COORD_W-1:0] v2_x;
  logic signed [COORD_W-1:0] v2_y;
  logic signed [COORD_W-1:0] v2_z;

  modport source(output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                 input ready);
  modport sink(input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
               output ready);
endinterface
`default_nettype wire

// ===== sv/tfc_out_if.sv =====
`default_nettype none
interface tfc_out_if import tfc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [COS_W-1:0] facing_cosine;
  logic                    degenerate;

  modport source(output valid, facing_cosine, degenerate, input ready);
  modport sink(input valid, facing_cosine, degenerate, output ready);
endinterface
`default_nettype wire

// ===== sv/triangle_facing_cosine_top.sv =====
`default_nettype none
// Channel   Dir  Payload                                   Transfer when
// in_tri    in   v0_x..v2_z, 9 x signed Q16.16             valid && ready
// out_res   out  facing_cosine (signed Q1.15), degenerate  valid && ready
//
// One triangle per cycle enters unless held; each result passes the front,
// product, divider and square-root stages, then the output register. The depth
// is set by the 33-bit restoring divider and 17-bit root, one bit a stage.
// Reset (rst_n low, synchronous) clears every valid bit; data needs none.
// All stages advance together; they hold only when the last stage has a result
// and the output register is full and not taken, so bubbles still drain.
module triangle_facing_cosine_top import tfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tfc_in_if.sink     in_tri,
  tfc_out_if.source  out_res
);

  logic       adv;
  triangle_t  trgl;
  logic       fr_vld;
  nrm_vec_t   fr_nrm;
  coord_vec_t fr_v0;
  side_t      pd_sd;
  logic [P_W-1:0] pd_p;
  logic [R_W-1:0] pd_r;
  side_t      dv_sd;
  logic [Q_W-1:0] dv_q;
  logic       sq_vld;
  logic [COS_W-1:0] sq_cos;
  logic       sq_deg;

  logic             out_valid_r;
  logic [COS_W-1:0] out_cos_r;
  logic             out_deg_r;

  // Hold the whole pipeline only when a finished result has nowhere to go
  assign adv          = !(sq_vld && out_valid_r && !out_res.ready);
  assign in_tri.ready = adv;

  assign trgl.v0.x = in_tri.v0_x;
  assign trgl.v0.y = in_tri.v0_y;
  assign trgl.v0.z = in_tri.v0_z;
  assign trgl.v1.x = in_tri.v1_x;
  assign trgl.v1.y = in_tri.v1_y;
  assign trgl.v1.z = in_tri.v1_z;
  assign trgl.v2.x = in_tri.v2_x;
  assign trgl.v2.y = in_tri.v2_y;
  assign trgl.v2.z = in_tri.v2_z;

  // Edges and face normal
  tfc_front u_front (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(in_tri.valid), .trgl(trgl),
    .out_vld(fr_vld), .nrm(fr_nrm), .v0(fr_v0)
  );

  // n . v0 and the squared lengths; P = |n|^2 |v0|^2, R = (65536 |n . v0|)^2
  tfc_prod u_prod (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(fr_vld), .nrm(fr_nrm), .v0(fr_v0),
    .sd(pd_sd), .p(pd_p), .r(pd_r)
  );

  // floor(R / P), at most 2^32 since the cosine is at most one
  tfc_div u_div (
    .clk(clk), .rst_n(rst_n), .en(adv), .sd_in(pd_sd), .p(pd_p), .r(pd_r),
    .sd_out(dv_sd), .q(dv_q)
  );

  // Largest m with (2m-1)^2 <= R/P is (isqrt + 1) / 2; apply sign and clamp
  tfc_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(adv), .sd_in(dv_sd), .q(dv_q),
    .out_vld(sq_vld), .cos(sq_cos), .deg(sq_deg)
  );

  // Output register: load a finished result, drop valid once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && sq_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && sq_vld) begin
      out_cos_r <= sq_cos;
      out_deg_r <= sq_deg;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.facing_cosine = out_cos_r;
  assign out_res.degenerate    = out_deg_r;

`ifndef NO_ASSERTIONS
  a_deg_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.degenerate |-> out_res.facing_cosine == '0)
    else $error("degenerate result with nonzero cosine");

  a_quot_range : assert property (@(posedge clk) disable iff (!rst_n)
    dv_sd.vld && !dv_sd.deg |-> dv_q <= Q_MAX)
    else $error("divider quotient above 2^32");

  a_out_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_res.valid) |-> $past(sq_vld && adv))
    else $error("output valid without a finished item");
`endif

endmodule
`default_nettype wire

// ===== sv/tfc_mul.sv =====
`default_nettype none
// Two-stage unsigned multiplier: four half-width partial products, then their sum.
module tfc_mul import tfc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] p
);

  logic [MUL_W-1:0]  pp_hh_r, pp_hl_r, pp_lh_r, pp_ll_r;
  logic [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh_r <= MUL_W'(a[MUL_W-1:MUL_H]) * MUL_W'(b[MUL_W-1:MUL_H]);
      pp_hl_r <= MUL_W'(a[MUL_W-1:MUL_H]) * MUL_W'(b[MUL_H-1:0]);
      pp_lh_r <= MUL_W'(a[MUL_H-1:0]) * MUL_W'(b[MUL_W-1:MUL_H]);
      pp_ll_r <= MUL_W'(a[MUL_H-1:0]) * MUL_W'(b[MUL_H-1:0]);
      p_r     <= (PROD_W'(pp_hh_r) << MUL_W)
               + ((PROD_W'(pp_hl_r) + PROD_W'(pp_lh_r)) << MUL_H)
               + PROD_W'(pp_ll_r);
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ===== sv/tfc_front.sv =====
`default_nettype none
// Edges, cross product: four stages from triangle to face normal.
module tfc_front import tfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_vld,
  input  triangle_t  trgl,
  output logic       out_vld,
  output nrm_vec_t   nrm,
  output coord_vec_t v0
);

  logic       vld_a_r, vld_b_r, vld_c_r, vld_d_r;
  edge_vec_t  e1_r, e2_r;
  coord_vec_t v0_a_r, v0_b_r, v0_c_r, v0_d_r;
  logic [5:0] sgn, sgn_b_r, sgn_c_r;
  nrm_vec_t   nrm_r;

  logic [MUL_W-1:0]  ma [6];
  logic [MUL_W-1:0]  mb [6];
  logic [PROD_W-1:0] pr [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      vld_d_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r.x  <= EDGE_W'(trgl.v1.x) - EDGE_W'(trgl.v0.x);
      e1_r.y  <= EDGE_W'(trgl.v1.y) - EDGE_W'(trgl.v0.y);
      e1_r.z  <= EDGE_W'(trgl.v1.z) - EDGE_W'(trgl.v0.z);
      e2_r.x  <= EDGE_W'(trgl.v2.x) - EDGE_W'(trgl.v0.x);
      e2_r.y  <= EDGE_W'(trgl.v2.y) - EDGE_W'(trgl.v0.y);
      e2_r.z  <= EDGE_W'(trgl.v2.z) - EDGE_W'(trgl.v0.z);
      v0_a_r  <= trgl.v0;
      v0_b_r  <= v0_a_r;
      v0_c_r  <= v0_b_r;
      v0_d_r  <= v0_c_r;
      sgn_b_r <= sgn;
      sgn_c_r <= sgn_b_r;
      nrm_r.x <= sgn_nrm(pr[0], sgn_c_r[0]) - sgn_nrm(pr[1], sgn_c_r[1]);
      nrm_r.y <= sgn_nrm(pr[2], sgn_c_r[2]) - sgn_nrm(pr[3], sgn_c_r[3]);
      nrm_r.z <= sgn_nrm(pr[4], sgn_c_r[4]) - sgn_nrm(pr[5], sgn_c_r[5]);
    end
  end

  // Operand pairs of the six cross-product terms
  always_comb begin
    ma[0] = abs_edge(e1_r.y);  mb[0] = abs_edge(e2_r.z);
    ma[1] = abs_edge(e1_r.z);  mb[1] = abs_edge(e2_r.y);
    ma[2] = abs_edge(e1_r.z);  mb[2] = abs_edge(e2_r.x);
    ma[3] = abs_edge(e1_r.x);  mb[3] = abs_edge(e2_r.z);
    ma[4] = abs_edge(e1_r.x);  mb[4] = abs_edge(e2_r.y);
    ma[5] = abs_edge(e1_r.y);  mb[5] = abs_edge(e2_r.x);
    sgn[0] = e1_r.y[EDGE_W-1] ^ e2_r.z[EDGE_W-1];
    sgn[1] = e1_r.z[EDGE_W-1] ^ e2_r.y[EDGE_W-1];
    sgn[2] = e1_r.z[EDGE_W-1] ^ e2_r.x[EDGE_W-1];
    sgn[3] = e1_r.x[EDGE_W-1] ^ e2_r.z[EDGE_W-1];
    sgn[4] = e1_r.x[EDGE_W-1] ^ e2_r.y[EDGE_W-1];
    sgn[5] = e1_r.y[EDGE_W-1] ^ e2_r.x[EDGE_W-1];
  end

  for (genvar i = 0; i < 6; i++) begin : g_mul
    tfc_mul u_mul (.clk(clk), .en(en), .a(ma[i]), .b(mb[i]), .p(pr[i]));
  end

  assign out_vld = vld_d_r;
  assign nrm     = nrm_r;
  assign v0      = v0_d_r;

endmodule
`default_nettype wire

// ===== sv/tfc_prod.sv =====
`default_nettype none
// Dot product and squared lengths, then the two sides of the squared comparison.
module tfc_prod import tfc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  nrm_vec_t         nrm,
  input  coord_vec_t       v0,
  output side_t            sd,
  output logic [P_W-1:0]   p,
  output logic [R_W-1:0]   r
);

  logic [MUL_W-1:0]  ma [9];
  logic [MUL_W-1:0]  mb [9];
  logic [PROD_W-1:0] pr [9];
  logic [MUL_W-1:0]  ma2 [5];
  logic [MUL_W-1:0]  mb2 [5];
  logic [PROD_W-1:0] pr2 [5];

  logic [2:0] dsg, dsg_a_r, dsg_b_r;
  logic       vld_a_r, vld_b_r, vld_c_r;
  side_t      sd_d_r, sd_e_r, sd_f_r, sd_g_r;

  logic signed [DOT_W-1:0] dot_c_r;
  logic [N2_W-1:0]         n2_c_r, n2_d_r;
  logic [P2_W-1:0]         p2_c_r, p2_d_r;
  logic [DABS_W-1:0]       dabs_d_r;
  logic [DOT_W-1:0]        dmag;
  logic [P_W-1:0]          p_r;
  logic [DSQ_W-1:0]        dsq;
  logic [R_W-1:0]          r_r;

  always_comb begin
    ma[0] = abs_nrm(nrm.x);   mb[0] = abs_coord(v0.x);
    ma[1] = abs_nrm(nrm.y);   mb[1] = abs_coord(v0.y);
    ma[2] = abs_nrm(nrm.z);   mb[2] = abs_coord(v0.z);
    ma[3] = abs_nrm(nrm.x);   mb[3] = abs_nrm(nrm.x);
    ma[4] = abs_nrm(nrm.y);   mb[4] = abs_nrm(nrm.y);
    ma[5] = abs_nrm(nrm.z);   mb[5] = abs_nrm(nrm.z);
    ma[6] = abs_coord(v0.x);  mb[6] = abs_coord(v0.x);
    ma[7] = abs_coord(v0.y);  mb[7] = abs_coord(v0.y);
    ma[8] = abs_coord(v0.z);  mb[8] = abs_coord(v0.z);
    dsg[0] = nrm.x[NRM_W-1] ^ v0.x[COORD_W-1];
    dsg[1] = nrm.y[NRM_W-1] ^ v0.y[COORD_W-1];
    dsg[2] = nrm.z[NRM_W-1] ^ v0.z[COORD_W-1];
  end

  for (genvar i = 0; i < 9; i++) begin : g_mul1
    tfc_mul u_mul (.clk(clk), .en(en), .a(ma[i]), .b(mb[i]), .p(pr[i]));
  end

  assign dmag = dot_c_r[DOT_W-1] ? DOT_W'(-dot_c_r) : DOT_W'(dot_c_r);

  // Split |n|^2 and |D| so each piece fits one multiplier
  always_comb begin
    ma2[0] = MUL_W'(n2_d_r[N2_W-1:N2LO_W]);      mb2[0] = MUL_W'(p2_d_r);
    ma2[1] = MUL_W'(n2_d_r[N2LO_W-1:0]);         mb2[1] = MUL_W'(p2_d_r);
    ma2[2] = MUL_W'(dabs_d_r[DABS_W-1:DLO_W]);   mb2[2] = MUL_W'(dabs_d_r[DABS_W-1:DLO_W]);
    ma2[3] = MUL_W'(dabs_d_r[DABS_W-1:DLO_W]);   mb2[3] = MUL_W'(dabs_d_r[DLO_W-1:0]);
    ma2[4] = MUL_W'(dabs_d_r[DLO_W-1:0]);        mb2[4] = MUL_W'(dabs_d_r[DLO_W-1:0]);
  end

  for (genvar i = 0; i < 5; i++) begin : g_mul2
    tfc_mul u_mul (.clk(clk), .en(en), .a(ma2[i]), .b(mb2[i]), .p(pr2[i]));
  end

  assign dsq = (DSQ_W'(pr2[2]) << (2 * DLO_W))
             + (DSQ_W'(pr2[3]) << (DLO_W + 1))
             + DSQ_W'(pr2[4]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      sd_d_r  <= '0;
      sd_e_r  <= '0;
      sd_f_r  <= '0;
      sd_g_r  <= '0;
    end else if (en) begin
      vld_a_r    <= in_vld;
      vld_b_r    <= vld_a_r;
      vld_c_r    <= vld_b_r;
      sd_d_r.vld <= vld_c_r;
      sd_d_r.neg <= dot_c_r[DOT_W-1];
      sd_d_r.deg <= (n2_c_r == '0) || (p2_c_r == '0);
      sd_e_r     <= sd_d_r;
      sd_f_r     <= sd_e_r;
      sd_g_r     <= sd_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsg_a_r  <= dsg;
      dsg_b_r  <= dsg_a_r;
      dot_c_r  <= sgn_dot(pr[0], dsg_b_r[0]) + sgn_dot(pr[1], dsg_b_r[1])
                + sgn_dot(pr[2], dsg_b_r[2]);
      n2_c_r   <= N2_W'(pr[3]) + N2_W'(pr[4]) + N2_W'(pr[5]);
      p2_c_r   <= P2_W'(pr[6]) + P2_W'(pr[7]) + P2_W'(pr[8]);
      n2_d_r   <= n2_c_r;
      p2_d_r   <= p2_c_r;
      dabs_d_r <= dmag[DABS_W-1:0];
      p_r      <= (P_W'(pr2[0]) << N2LO_W) + P_W'(pr2[1]);
      r_r      <= {dsq, {SCALE_SH{1'b0}}};
    end
  end

  assign sd = sd_g_r;
  assign p  = p_r;
  assign r  = r_r;

endmodule
`default_nettype wire

// ===== sv/tfc_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per stage, most significant bit first.
module tfc_div import tfc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  side_t          sd_in,
  input  logic [P_W-1:0] p,
  input  logic [R_W-1:0] r,
  output side_t          sd_out,
  output logic [Q_W-1:0] q
);

  side_t          sd_r  [Q_W];
  logic [R_W-1:0] rem_r [Q_W];
  logic [P_W-1:0] dvs_r [Q_W];
  logic [Q_W-1:0] q_r   [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stg
    side_t          sd_k;
    logic [R_W-1:0] rem_k;
    logic [P_W-1:0] dvs_k;
    logic [Q_W-1:0] q_k;
    logic [R_W-1:0] shifted;
    logic [R_W:0]   diff;

    if (k == 0) begin : g_first
      assign sd_k  = sd_in;
      assign rem_k = r;
      assign dvs_k = p;
      assign q_k   = '0;
    end else begin : g_next
      assign sd_k  = sd_r[k-1];
      assign rem_k = rem_r[k-1];
      assign dvs_k = dvs_r[k-1];
      assign q_k   = q_r[k-1];
    end

    assign shifted = R_W'(dvs_k) << (Q_W - 1 - k);
    assign diff    = {1'b0, rem_k} - {1'b0, shifted};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[k] <= '0;
      end else if (en) begin
        sd_r[k] <= sd_k;
      end
    end

    // Keep the remainder when the trial subtract borrows
    always_ff @(posedge clk) begin
      if (en) begin
        dvs_r[k] <= dvs_k;
        q_r[k]   <= {q_k[Q_W-2:0], ~diff[R_W]};
        rem_r[k] <= diff[R_W] ? rem_k : diff[R_W-1:0];
      end
    end
  end

  assign sd_out = sd_r[Q_W-1];
  assign q      = q_r[Q_W-1];

endmodule
`default_nettype wire

// ===== sv/tfc_sqrt.sv =====
`default_nettype none
// Integer square root, one root bit per stage, then rounding, sign and clamp.
module tfc_sqrt import tfc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  side_t            sd_in,
  input  logic [Q_W-1:0]   q,
  output logic             out_vld,
  output logic [COS_W-1:0] cos,
  output logic             deg
);

  side_t            sd_r   [S_W];
  logic [RAD_W-1:0] rad_r  [S_W];
  logic [RM_W-1:0]  rem_r  [S_W];
  logic [S_W-1:0]   root_r [S_W];

  for (genvar k = 0; k < S_W; k++) begin : g_stg
    side_t            sd_k;
    logic [RAD_W-1:0] rad_k;
    logic [RM_W-1:0]  rem_k;
    logic [S_W-1:0]   root_k;
    logic [RM_W-1:0]  cur;
    logic [RM_W-1:0]  trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign sd_k   = sd_in;
      assign rad_k  = RAD_W'(q);
      assign rem_k  = '0;
      assign root_k = '0;
    end else begin : g_next
      assign sd_k   = sd_r[k-1];
      assign rad_k  = rad_r[k-1];
      assign rem_k  = rem_r[k-1];
      assign root_k = root_r[k-1];
    end

    assign cur   = {rem_k[RM_W-3:0], rad_k[RAD_W-1:RAD_W-2]};
    assign trial = RM_W'({root_k, 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[k] <= '0;
      end else if (en) begin
        sd_r[k] <= sd_k;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_k << 2;
        rem_r[k]  <= ge ? (cur - trial) : cur;
        root_r[k] <= {root_k[S_W-2:0], ge};
      end
    end
  end

  logic [S_W:0]   s_inc;
  logic [S_W-1:0] m;
  logic [S_W-1:0] m_neg;
  side_t          sd_last;

  assign sd_last = sd_r[S_W-1];
  assign s_inc   = (S_W+1)'(root_r[S_W-1]) + (S_W+1)'(1);
  assign m       = s_inc[S_W:1];
  assign m_neg   = -m;

  always_comb begin
    priority if (sd_last.deg) begin
      cos = '0;
    end else if (sd_last.neg) begin
      cos = m_neg[COS_W-1:0];
    end else if (m > S_W'(COS_MAX)) begin
      cos = COS_MAX;
    end else begin
      cos = m[COS_W-1:0];
    end
  end

  assign out_vld = sd_last.vld;
  assign deg     = sd_last.deg;

endmodule
`default_nettype wire

// ===== tb/tfc_checker.sv =====
`default_nettype none
module tfc_checker import tfc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tfc_in_if    tri_ch,
  tfc_out_if   res_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [447:0] wide_t;

  typedef struct packed {
    logic signed [COS_W-1:0] cosine;
    logic                    deg;
  } facing_t;

  facing_t facing_q[$];

  function automatic wide_t widen(input logic signed [COORD_W-1:0] v);
    wide_t w;
    w = v;
    return w;
  endfunction

  // Exact facing cosine: compare squares, no rounding on the way
  function automatic facing_t facing_of(input triangle_t t);
    wide_t   a0x, a0y, a0z, e1x, e1y, e1z, e2x, e2y, e2z;
    wide_t   nx, ny, nz, dot, n2, p2, prod, ad, rhs, odd, lhs;
    int      lo, hi, mid;
    logic    neg;
    facing_t r;
    a0x = widen(t.v0.x);
    a0y = widen(t.v0.y);
    a0z = widen(t.v0.z);
    e1x = widen(t.v1.x) - a0x;
    e1y = widen(t.v1.y) - a0y;
    e1z = widen(t.v1.z) - a0z;
    e2x = widen(t.v2.x) - a0x;
    e2y = widen(t.v2.y) - a0y;
    e2z = widen(t.v2.z) - a0z;
    nx = e1y * e2z - e1z * e2y;
    ny = e1z * e2x - e1x * e2z;
    nz = e1x * e2y - e1y * e2x;
    dot = nx * a0x + ny * a0y + nz * a0z;
    n2 = nx * nx + ny * ny + nz * nz;
    p2 = a0x * a0x + a0y * a0y + a0z * a0z;
    if (n2 == 0 || p2 == 0) begin
      r.cosine = '0;
      r.deg = 1'b1;
      return r;
    end
    prod = n2 * p2;
    neg = dot < 0;
    ad = neg ? -dot : dot;
    ad = ad * 65536;
    rhs = ad * ad;
    // largest m with (2m-1)^2 * P <= rhs gives round half away from zero
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 2 * mid - 1;
      lhs = odd * odd * prod;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (neg) r.cosine = COS_W'(-lo);
    else r.cosine = (lo > 32767) ? COS_MAX : COS_W'(lo);
    r.deg = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    facing_t got, want;
    triangle_t t;
    if (rst_n) begin
      if (tri_ch.valid && tri_ch.ready) begin
        t = {tri_ch.v0_x, tri_ch.v0_y, tri_ch.v0_z, tri_ch.v1_x, tri_ch.v1_y,
             tri_ch.v1_z, tri_ch.v2_x, tri_ch.v2_y, tri_ch.v2_z};
        facing_q.push_back(facing_of(t));
      end
      if (res_ch.valid && res_ch.ready) begin
        got.cosine = res_ch.facing_cosine;
        got.deg = res_ch.degenerate;
        if (facing_q.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          want = facing_q.pop_front();
          if (got.cosine !== want.cosine)
            report_mismatch($sformatf("facing_cosine %0d, want %0d",
                                      got.cosine, want.cosine));
          if (got.deg !== want.deg)
            report_mismatch($sformatf("degenerate %0b, want %0b", got.deg, want.deg));
        end
      end
    end
    pending = facing_q.size();
  end
endmodule
`default_nettype wire

// ===== tb/tb_triangle_facing_cosine_top.sv =====
`default_nettype none
module tb_triangle_facing_cosine_top import tfc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;

  // Receiver controls: a long hold requested by the stimulus process and
  // a calm flag that turns off random idling on both sides.
  int   hold_cycles;
  bit   calm;

  tfc_in_if  tri_ch ();
  tfc_out_if res_ch ();

  triangle_facing_cosine_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tri  (tri_ch),
    .out_res (res_ch)
  );

  tfc_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tri_ch     (tri_ch),
    .res_ch     (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: stall for a random count after every transfer unless calm, and
  // honor any long hold the stimulus asks for.
  initial begin
    int stall_left;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready)
        stall_left = calm ? 0 : $urandom_range(0, 9);
      if (hold_cycles > 0) begin
        hold_cycles--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= rst_n;
      end
    end
  end

  function automatic coord_vec_t make_vec(input logic signed [COORD_W-1:0] x,
                                          input logic signed [COORD_W-1:0] y,
                                          input logic signed [COORD_W-1:0] z);
    coord_vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  function automatic triangle_t make_tri(input coord_vec_t a, input coord_vec_t b,
                                         input coord_vec_t c);
    triangle_t t;
    t.v0 = a;
    t.v1 = b;
    t.v2 = c;
    return t;
  endfunction

  // Pick a coordinate: full range, Q16.16 scene-sized, or tiny for near-degenerate
  function automatic logic signed [COORD_W-1:0] rand_coord(input int span);
    case (span)
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: return $signed($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  function automatic coord_vec_t rand_vec(input int span);
    return make_vec(rand_coord(span), rand_coord(span), rand_coord(span));
  endfunction

  function automatic triangle_t rand_tri();
    int        span, shape;
    coord_vec_t a, b, c;
    span = $urandom_range(0, 9) < 3 ? 0 : ($urandom_range(0, 9) < 8 ? 1 : 2);
    a = rand_vec(span);
    b = rand_vec(span);
    c = rand_vec(span);
    shape = $urandom_range(0, 19);
    // Mix in collinear edges, a repeated vertex and vertex 0 at the origin now and then
    if (shape == 0) begin
      c.x = a.x + 2 * (b.x - a.x);
      c.y = a.y + 2 * (b.y - a.y);
      c.z = a.z + 2 * (b.z - a.z);
    end else if (shape == 1) begin
      a = '0;
    end else if (shape == 2) begin
      c = b;
    end
    return make_tri(a, b, c);
  endfunction

  // Offer one triangle after a random gap; hold valid across back-to-back transfers
  task automatic send_tri(input triangle_t t);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      tri_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tri_ch.valid <= 1'b1;
    {tri_ch.v0_x, tri_ch.v0_y, tri_ch.v0_z, tri_ch.v1_x, tri_ch.v1_y,
     tri_ch.v1_z, tri_ch.v2_x, tri_ch.v2_y, tri_ch.v2_z} <= t;
    do @(posedge clk); while (!tri_ch.ready);
  endtask

  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] ONE   = 32'sh0001_0000;

  initial begin
    triangle_t directed_q[$];
    int        drain;

    calm = 1'b0;
    hold_cycles = 0;
    rst_n = 1'b0;
    tri_ch.valid = 1'b0;
    {tri_ch.v0_x, tri_ch.v0_y, tri_ch.v0_z, tri_ch.v1_x, tri_ch.v1_y,
     tri_ch.v1_z, tri_ch.v2_x, tri_ch.v2_y, tri_ch.v2_z} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: facing straight on in both windings (clamp at plus one,
    // exact minus one), both degenerate kinds, range extremes, all bits set
    directed_q.push_back(make_tri(make_vec(0, 0, ONE), make_vec(ONE, 0, ONE),
                                  make_vec(0, ONE, ONE)));
    directed_q.push_back(make_tri(make_vec(0, 0, ONE), make_vec(0, ONE, ONE),
                                  make_vec(ONE, 0, ONE)));
    directed_q.push_back(make_tri(make_vec(0, 0, 1), make_vec(1, 0, 1),
                                  make_vec(0, 1, 1)));
    directed_q.push_back('0);
    directed_q.push_back(make_tri('0, make_vec(ONE, 0, 0), make_vec(0, ONE, 0)));
    directed_q.push_back(make_tri(make_vec(ONE, ONE, ONE), make_vec(2*ONE, 2*ONE, 2*ONE),
                                  make_vec(3*ONE, 3*ONE, 3*ONE)));
    directed_q.push_back(make_tri(make_vec(ONE, 0, 0), make_vec(ONE, ONE, 0),
                                  make_vec(ONE, 0, ONE)));
    directed_q.push_back(make_tri(make_vec(ONE, 0, ONE), make_vec(2*ONE, 0, ONE),
                                  make_vec(ONE, 0, 2*ONE)));
    directed_q.push_back(make_tri(make_vec(C_MAX, C_MAX, C_MAX),
                                  make_vec(C_MIN, C_MAX, C_MIN),
                                  make_vec(C_MIN, C_MIN, C_MAX)));
    directed_q.push_back(make_tri(make_vec(C_MIN, C_MIN, C_MIN),
                                  make_vec(C_MAX, C_MIN, C_MAX),
                                  make_vec(C_MAX, C_MAX, C_MIN)));
    directed_q.push_back(make_tri(make_vec(C_MIN, 0, 0), make_vec(C_MAX, C_MIN, 0),
                                  make_vec(C_MAX, 0, C_MIN)));
    directed_q.push_back(make_tri(make_vec(-1, -1, -1), make_vec(C_MAX, 0, 0),
                                  make_vec(0, C_MAX, 0)));
    directed_q.push_back(make_tri(make_vec(C_MAX, 0, 0), make_vec(C_MIN, C_MIN, C_MIN),
                                  make_vec(C_MIN, C_MAX, C_MAX)));
    directed_q.push_back(make_tri(make_vec(1, 0, 0), make_vec(1, 1, 0), make_vec(1, 0, 1)));
    foreach (directed_q[i]) send_tri(directed_q[i]);

    // Random body with the pressure phases mixed in
    for (int n = 0; n < 1200; n++) begin
      if (n % 300 == 150) calm = ~calm;
      if (n == 400) hold_cycles = 300;  // block fills up and stalls its input
      if (n == 700) begin
        // pause the sender until every outstanding result is back
        tri_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_tri(rand_tri());
    end
    tri_ch.valid <= 1'b0;
    calm = 1'b0;

    // Drain, then allow for the pipeline depth to catch stray results
    drain = 0;
    while (pending != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (100) @(posedge clk);
    if (pending == 0 && fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
